// File: src/jeo_pkg.sv
`default_nettype none
package jeo_pkg;

    localparam int JEO_MAX_PEOPLE = 64;
    localparam int FIELD_W        = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_PRIME,
        ST_WALK
    } t_state;

endpackage
`default_nettype wire

// File: src/josephus_elimination_order.sv
`default_nettype none
// Josephus elimination order.
// Input transaction: start with i_circle_size and i_step_count, taken at a
// rising edge where start is high and busy is low. A size of zero counts as
// one, a size above MAX_PEOPLE as MAX_PEOPLE, a step of zero as one.
// Results: one transaction per person, o_valid high for exactly one cycle
// with o_person, o_order_index and o_is_last; the final survivor comes last
// with o_is_last set. The receiver cannot stall; results are never held.
// Timing: after acceptance the alive table is refilled in ST_FILL, ST_PRIME
// primes the table read, then the walk visits one circle position per
// cycle (a single RAM read port and one counter compare). Empty places are
// walked too. busy stays high for the whole request; the next request can be
// taken in the cycle that shows the last result.
// Reset: synchronous, active low; returns to idle with no result pending.
module josephus_elimination_order #(
    parameter int MAX_PEOPLE = jeo_pkg::JEO_MAX_PEOPLE
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [jeo_pkg::FIELD_W-1:0] i_circle_size,
    input  wire logic [jeo_pkg::FIELD_W-1:0] i_step_count,
    output logic                             o_valid,
    output logic      [jeo_pkg::FIELD_W-1:0] o_person,
    output logic      [jeo_pkg::FIELD_W-1:0] o_order_index,
    output logic                             o_is_last
);

    import jeo_pkg::*;

    localparam int AW = $clog2(MAX_PEOPLE);
    localparam int SW = $clog2(MAX_PEOPLE + 1);
    localparam int PW = SW + FIELD_W;

    t_state             r_state, n_state;
    logic [SW-1:0]      r_size, n_size;
    logic [FIELD_W-1:0] r_step, n_step;
    logic [AW-1:0]      r_cur, n_cur;
    logic [AW-1:0]      r_fill, n_fill;
    logic [FIELD_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0]      r_rem, n_rem;
    logic [SW-1:0]      r_pos, n_pos;
    logic               r_valid, n_valid;
    logic [FIELD_W-1:0] r_person, n_person;
    logic [FIELD_W-1:0] r_index, n_index;
    logic               r_last, n_last;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic               ram_rdata;

    logic [FIELD_W-1:0] size_nz;
    logic [FIELD_W-1:0] step_nz;
    logic [AW-1:0]      last_addr;
    logic [AW-1:0]      next_cur;
    logic [PW-1:0]      person_ext;
    logic [PW-1:0]      pos_ext;

    jeo_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PEOPLE)
    ) u_alive (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_person      = r_person;
    assign o_order_index = r_index;
    assign o_is_last     = r_last;

    assign size_nz    = (i_circle_size == '0) ? FIELD_W'(1) : i_circle_size;
    assign step_nz    = (i_step_count == '0) ? FIELD_W'(1) : i_step_count;
    assign last_addr  = AW'(r_size - SW'(1));
    assign next_cur   = (r_cur == last_addr) ? '0 : r_cur + AW'(1);
    assign person_ext = PW'(r_cur) + PW'(1);
    assign pos_ext    = PW'(r_pos) + PW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_fill == last_addr) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (ram_rdata && r_rem == SW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and table access
    always_comb begin
        n_size    = r_size;
        n_step    = r_step;
        n_cur     = r_cur;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_pos     = r_pos;
        n_valid   = 1'b0;
        n_person  = r_person;
        n_index   = r_index;
        n_last    = r_last;
        ram_we    = 1'b0;
        ram_waddr = r_fill;
        ram_wdata = 1'b1;
        ram_raddr = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (int'(size_nz) > MAX_PEOPLE) begin
                        n_size = SW'(MAX_PEOPLE);
                    end else begin
                        n_size = SW'(size_nz);
                    end
                    n_step = step_nz;
                    n_fill = '0;
                end
            end
            ST_FILL: begin
                ram_we = 1'b1;
                n_fill = r_fill + AW'(1);
                n_cur  = '0;
                n_cnt  = FIELD_W'(1);
                n_rem  = r_size;
                n_pos  = '0;
            end
            ST_PRIME: begin
                ram_raddr = '0;
            end
            ST_WALK: begin
                ram_raddr = next_cur;
                n_cur     = next_cur;
                if (ram_rdata) begin
                    if (r_rem == SW'(1)) begin
                        n_valid  = 1'b1;
                        n_person = person_ext[FIELD_W-1:0];
                        n_index  = pos_ext[FIELD_W-1:0];
                        n_last   = 1'b1;
                        n_pos    = pos_ext[SW-1:0];
                    end else if (r_cnt == r_step) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_cur;
                        ram_wdata = 1'b0;
                        n_valid   = 1'b1;
                        n_person  = person_ext[FIELD_W-1:0];
                        n_index   = pos_ext[FIELD_W-1:0];
                        n_last    = 1'b0;
                        n_pos     = pos_ext[SW-1:0];
                        n_rem     = r_rem - SW'(1);
                        n_cnt     = FIELD_W'(1);
                    end else begin
                        n_cnt = r_cnt + FIELD_W'(1);
                    end
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cur   <= '0;
            r_cnt   <= FIELD_W'(1);
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cur   <= n_cur;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size   <= n_size;
        r_step   <= n_step;
        r_fill   <= n_fill;
        r_pos    <= n_pos;
        r_person <= n_person;
        r_index  <= n_index;
        r_last   <= n_last;
    end

`ifndef SYNTH
    a_no_result_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL || r_state == ST_PRIME) |-> !o_valid)
        else $error("result during table refill");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> !busy)
        else $error("survivor shown while still busy");

    a_start_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_FILL))
        else $error("accepted transaction did not start refill");

    a_remaining_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_rem >= SW'(1) && r_rem <= r_size))
        else $error("remaining count out of range");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (SW'(r_cur) < r_size))
        else $error("cursor outside circle");
`endif

endmodule
`default_nettype wire

// File: src/jeo_ram.sv
`default_nettype none
module jeo_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
